@@ rtl/bbcc_pkg.sv @@
// Shared types and constants for the basic block code cache.
package bbcc_pkg;

  localparam int CacheEntriesDef = 16;
  localparam int BlockWordsDef   = 64;

  typedef enum logic [1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_CAPTURE = 2'd1,
    KIND_FIND    = 2'd2,
    KIND_READ    = 2'd3
  } kind_e;

  // Opcodes (top nibble) that end a basic block.
  localparam logic [3:0] OP_BRANCH = 4'h0;
  localparam logic [3:0] OP_JUMP   = 4'h4;
  localparam logic [3:0] OP_JSR    = 4'hC;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] start_address;
    logic [15:0] instr_word;
    logic        first_word;
    logic [3:0]  entry_select;
    logic [5:0]  word_select;
  } cmd_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  found_entry;
    logic [6:0]  block_length;
    logic [15:0] read_data;
    logic        block_closed;
    logic        block_overflow;
  } rsp_t;

  function automatic logic ends_block(logic [15:0] word);
    logic [3:0] op;
    op = word[15:12];
    return (op == OP_BRANCH) || (op == OP_JUMP) || (op == OP_JSR);
  endfunction

endpackage

@@ rtl/bbcc_cmd_if.sv @@
// Request channel: valid/ready handshake carrying one cache request.
interface bbcc_cmd_if;
  logic            valid;
  logic            ready;
  bbcc_pkg::cmd_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/bbcc_rsp_if.sv @@
// Response channel: valid/ready handshake carrying one cache response.
interface bbcc_rsp_if;
  logic            valid;
  logic            ready;
  bbcc_pkg::rsp_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/bbcc_bank_map.sv @@
// Entry-to-bank map for the code store, with a spare staging bank swapped in on close.
module bbcc_bank_map #(
  parameter int CACHE_ENTRIES = bbcc_pkg::CacheEntriesDef,
  localparam int EW  = $clog2(CACHE_ENTRIES),
  localparam int BKW = $clog2(CACHE_ENTRIES + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           lookup_en_i,
  input  logic [EW-1:0]  lookup_idx_i,
  output logic [BKW-1:0] bank_o,
  output logic [BKW-1:0] stage_bank_o,
  input  logic           swap_en_i,
  input  logic [EW-1:0]  swap_idx_i
);
  import bbcc_pkg::*;

  logic [BKW-1:0]           map_mem [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] mvalid_q;
  logic [BKW-1:0]           stage_q;
  logic [BKW-1:0]           rd_q;
  logic                     rd_valid_q;
  logic [EW-1:0]            rd_idx_q;

  // Entries never remapped still own the bank of their own number.
  assign bank_o       = rd_valid_q ? rd_q : BKW'(rd_idx_q);
  assign stage_bank_o = stage_q;

  always_ff @(posedge clk_i) begin
    if (swap_en_i) begin
      map_mem[swap_idx_i] <= stage_q;
    end
    if (lookup_en_i) begin
      rd_q     <= map_mem[lookup_idx_i];
      rd_idx_q <= lookup_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mvalid_q   <= '0;
      stage_q    <= BKW'(CACHE_ENTRIES);
      rd_valid_q <= 1'b0;
    end else begin
      if (lookup_en_i) begin
        rd_valid_q <= mvalid_q[lookup_idx_i];
      end
      if (swap_en_i) begin
        mvalid_q[swap_idx_i] <= 1'b1;
        stage_q              <= bank_o;
      end
    end
  end

endmodule

@@ rtl/basic_block_code_cache_unit.sv @@
// Basic block code cache: captures instruction blocks, finds them by start address.
//
//   channel  dir  handshake          payload
//   cmd_i    in   valid/ready        bbcc_pkg::cmd_t (kind, address, word, selects)
//   rsp_o    out  valid/ready        bbcc_pkg::rsp_t (hit, entry, length, data, flags)
//
// One request at a time; every request gives exactly one response.
// A closing capture writes its tag and swaps in the staging bank before it responds; a read
// reads the tag and map together, then the code memory; a find reads the tags in use in
// order, one tag read a cycle, and stops at the first match.
// Reset empties the table and the open block; the memories are not cleared.
// The response register frees the request side: a new request is taken while a
// response waits; a request only stalls at its last step when rsp_o is held.
module basic_block_code_cache_unit #(
  parameter int CACHE_ENTRIES = bbcc_pkg::CacheEntriesDef,
  parameter int BLOCK_WORDS   = bbcc_pkg::BlockWordsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bbcc_cmd_if.sink    cmd_i,
  bbcc_rsp_if.source  rsp_o
);
  import bbcc_pkg::*;

  localparam int EW    = $clog2(CACHE_ENTRIES);
  localparam int CW    = $clog2(CACHE_ENTRIES + 1);
  localparam int BKW   = CW;
  localparam int LW    = $clog2(BLOCK_WORDS + 1);
  localparam int WW    = $clog2(BLOCK_WORDS);
  localparam int AW    = BKW + WW;
  localparam int DEPTH = (CACHE_ENTRIES + 1) << WW;
  localparam int TW    = 16 + LW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLOSE = 3'd1;
  localparam logic [2:0] S_FIND  = 3'd2;
  localparam logic [2:0] S_RD1   = 3'd3;
  localparam logic [2:0] S_RD2   = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [15:0]   cap_start_q, cap_start_d;
  logic [LW-1:0] cap_fill_q, cap_fill_d;
  cmd_t          req_q, req_d;
  logic [EW-1:0] slot_q, slot_d;
  logic [LW-1:0] close_len_q, close_len_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [EW-1:0] pidx_q, pidx_d;
  logic          pend_q, pend_d;
  rsp_t          res_q, res_d;
  logic          rsp_valid_q, rsp_valid_d;
  rsp_t          rsp_data_q, rsp_data_d;

  logic [TW-1:0] tag_mem [CACHE_ENTRIES];
  logic [TW-1:0] tag_rd_q;
  logic          tag_we, tag_ren;
  logic [EW-1:0] tag_waddr, tag_raddr;
  logic [TW-1:0] tag_wdata;

  logic [15:0]   code_mem [DEPTH];
  logic [15:0]   code_rd_q;
  logic          code_we, code_ren;
  logic [AW-1:0] code_waddr, code_raddr;

  logic           map_lookup_en, map_swap_en;
  logic [EW-1:0]  map_lookup_idx;
  logic [BKW-1:0] bank, stage_bank;

  logic          accept, out_free;
  logic          restart, br, full, closing;
  logic [LW-1:0] fill0, fill1;
  logic [EW-1:0] slot_new;
  logic [15:0]   tag_start;
  logic [LW-1:0] tag_len;

  bbcc_bank_map #(
    .CACHE_ENTRIES(CACHE_ENTRIES)
  ) u_bank_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lookup_en_i (map_lookup_en),
    .lookup_idx_i(map_lookup_idx),
    .bank_o      (bank),
    .stage_bank_o(stage_bank),
    .swap_en_i   (map_swap_en),
    .swap_idx_i  (slot_q)
  );

  assign cmd_i.ready = (state_q == S_IDLE);
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_data_q;
  assign out_free    = !rsp_valid_q || rsp_o.ready;

  assign restart  = cmd_i.data.first_word || (cap_fill_q == '0);
  assign fill0    = restart ? '0 : cap_fill_q;
  assign fill1    = fill0 + LW'(1);
  assign br       = ends_block(cmd_i.data.instr_word);
  assign full     = (fill1 == LW'(BLOCK_WORDS));
  assign closing  = br || full;
  assign slot_new = (count_q < CW'(CACHE_ENTRIES)) ? EW'(count_q) : EW'(CACHE_ENTRIES - 1);

  assign tag_start = tag_rd_q[TW-1 -: 16];
  assign tag_len   = tag_rd_q[LW-1:0];

  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    cap_start_d    = cap_start_q;
    cap_fill_d     = cap_fill_q;
    req_d          = req_q;
    slot_d         = slot_q;
    close_len_d    = close_len_q;
    idx_d          = idx_q;
    pidx_d         = pidx_q;
    pend_d         = pend_q;
    res_d          = res_q;
    rsp_valid_d    = rsp_valid_q && !rsp_o.ready;
    rsp_data_d     = rsp_data_q;
    tag_we         = 1'b0;
    tag_waddr      = slot_q;
    tag_wdata      = {cap_start_q, close_len_q};
    tag_ren        = 1'b0;
    tag_raddr      = EW'(idx_q);
    code_we        = 1'b0;
    code_waddr     = {stage_bank, WW'(fill0)};
    code_ren       = 1'b0;
    code_raddr     = {bank, WW'(req_q.word_select)};
    map_lookup_en  = 1'b0;
    map_lookup_idx = slot_new;
    map_swap_en    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d = cmd_i.data;
          res_d = '0;
          case (cmd_i.data.kind)
            KIND_CLEAR: begin
              count_d = '0;
              state_d = S_RESP;
            end
            KIND_CAPTURE: begin
              code_we     = 1'b1;
              cap_start_d = restart ? cmd_i.data.start_address : cap_start_q;
              if (closing) begin
                cap_fill_d            = '0;
                slot_d                = slot_new;
                close_len_d           = fill1;
                map_lookup_en         = 1'b1;
                res_d.block_closed    = 1'b1;
                res_d.block_overflow  = !br;
                res_d.found_entry     = 4'(slot_new);
                res_d.block_length    = 7'(fill1);
                if (count_q < CW'(CACHE_ENTRIES)) begin
                  count_d = count_q + CW'(1);
                end
                state_d = S_CLOSE;
              end else begin
                cap_fill_d = fill1;
                state_d    = S_RESP;
              end
            end
            KIND_FIND: begin
              idx_d   = '0;
              pend_d  = 1'b0;
              state_d = S_FIND;
            end
            KIND_READ: begin
              if (32'(cmd_i.data.entry_select) < 32'(count_q)) begin
                tag_ren        = 1'b1;
                tag_raddr      = EW'(cmd_i.data.entry_select);
                map_lookup_en  = 1'b1;
                map_lookup_idx = EW'(cmd_i.data.entry_select);
                state_d        = S_RD1;
              end else begin
                state_d = S_RESP;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_CLOSE: begin
        tag_we      = 1'b1;
        map_swap_en = 1'b1;
        state_d     = S_RESP;
      end
      S_FIND: begin
        if (pend_q && (tag_start == req_q.start_address)) begin
          res_d.hit          = 1'b1;
          res_d.found_entry  = 4'(pidx_q);
          res_d.block_length = 7'(tag_len);
          state_d            = S_RESP;
        end else if (idx_q < count_q) begin
          tag_ren = 1'b1;
          pend_d  = 1'b1;
          pidx_d  = EW'(idx_q);
          idx_d   = idx_q + CW'(1);
        end else begin
          state_d = S_RESP;
        end
      end
      S_RD1: begin
        if (32'(req_q.word_select) < 32'(tag_len)) begin
          code_ren = 1'b1;
          state_d  = S_RD2;
        end else begin
          state_d = S_RESP;
        end
      end
      S_RD2: begin
        res_d.hit       = 1'b1;
        res_d.read_data = code_rd_q;
        state_d         = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          rsp_valid_d = 1'b1;
          rsp_data_d  = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[tag_waddr] <= tag_wdata;
    end
    if (tag_ren) begin
      tag_rd_q <= tag_mem[tag_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (code_we) begin
      code_mem[code_waddr] <= cmd_i.data.instr_word;
    end
    if (code_ren) begin
      code_rd_q <= code_mem[code_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    slot_q      <= slot_d;
    close_len_q <= close_len_d;
    idx_q       <= idx_d;
    pidx_q      <= pidx_d;
    res_q       <= res_d;
    rsp_data_q  <= rsp_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cap_start_q <= '0;
      cap_fill_q  <= '0;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cap_start_q <= cap_start_d;
      cap_fill_q  <= cap_fill_d;
      pend_q      <= pend_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

endmodule
